// ===== src/set_assoc_lru_cache_sim_defines.svh =====
// Assertion macros for the set-associative cache block
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== src/slac_pkg.sv =====
package slac_pkg;

    localparam int TAG_W   = 63;
    localparam int STAMP_W = 64;
    localparam int ADDR_W  = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_CFG_W  = 3;
    localparam int OFF_CFG_W  = 6;
    localparam int WAY_CFG_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

    localparam logic [SET_CFG_W-1:0] SET_BITS_RST = 3'd1;
    localparam logic [OFF_CFG_W-1:0] OFF_BITS_RST = 6'd4;
    localparam logic [WAY_CFG_W-1:0] WAYS_RST     = 4'd1;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    localparam logic [1:0] OUT_MISS  = 2'd0;
    localparam logic [1:0] OUT_HIT   = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef struct packed {
        logic       hit;
        logic       evict;
        logic [1:0] outcome;
    } t_lookup;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } t_state;

endpackage

// ===== src/set_assoc_lru_cache_sim.sv =====
// A request accepted in the idle state reads its set row from the line memory; the evaluate
//   state registers its result and writes the row back, stalling while a response is held.
// A new request is taken only after the previous one has written its set row back.
// Reset: configuration returns to 1 set bit, 4 offset bits, 1 way; totals and clock clear;
//   a clearing pass zeroes every row of the line memory before the first request.
`include "set_assoc_lru_cache_sim_defines.svh"

module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [slac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slac_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic [1:0]                        i_mode,
    input  logic [slac_pkg::ADDR_W-1:0]       i_address,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output logic [1:0]                        o_outcome,
    output logic                              o_second_hit,
    output logic [31:0]                       o_hit_total,
    output logic [31:0]                       o_miss_total,
    output logic [31:0]                       o_eviction_total
);

    import slac_pkg::*;

    localparam int WIDX  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW   = $clog2(MAX_WAYS + 1);
    localparam int SBW   = $clog2(MAX_SET_BITS + 1);
    localparam int ROW_W = MAX_WAYS * $bits(t_line);
    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    t_state                   r_state;
    t_state                   n_state;
    logic [SET_CFG_W-1:0]     r_set_bits;
    logic [OFF_CFG_W-1:0]     r_off_bits;
    logic [WAY_CFG_W-1:0]     r_ways;
    logic [MAX_SET_BITS-1:0]  r_clr_addr;
    logic [MAX_SET_BITS-1:0]  r_set;
    logic [TAG_W-1:0]         r_tag;
    logic [1:0]               r_mode;
    logic [STAMP_W-1:0]       r_clock;
    logic [COUNT_WIDTH-1:0]   r_hit;
    logic [COUNT_WIDTH-1:0]   r_miss;
    logic [COUNT_WIDTH-1:0]   r_evict;
    logic                     r_rsp_valid;
    logic [1:0]               r_outcome;
    logic                     r_second;

    logic [SBW-1:0]           w_s_eff;
    logic [WCW-1:0]           w_w_eff;
    logic [MAX_SET_BITS-1:0]  w_set_mask;
    logic [ADDR_W-1:0]        w_set_shift;
    logic [MAX_SET_BITS-1:0]  w_set;
    logic [6:0]               w_tag_sh;
    logic [ADDR_W-1:0]        w_tag_shift;
    logic [TAG_W-1:0]         w_tag;

    logic                     w_done;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic [MAX_SET_BITS-1:0]  w_waddr;
    logic [ROW_W-1:0]         w_wdata;
    logic [ROW_W-1:0]         w_rdata;
    t_line [MAX_WAYS-1:0]     w_row;
    t_line [MAX_WAYS-1:0]     w_new_row;
    t_lookup                  w_res;
    logic [WIDX-1:0]          w_way;
    logic [STAMP_W-1:0]       w_clock_nx;
    logic                     w_modify;
    logic [1:0]               w_hit_inc;
    logic [COUNT_WIDTH:0]     w_hit_sum;
    logic [COUNT_WIDTH:0]     w_miss_sum;
    logic [COUNT_WIDTH:0]     w_evict_sum;
    logic [EXT_W-1:0]         w_hit_ext;
    logic [EXT_W-1:0]         w_miss_ext;
    logic [EXT_W-1:0]         w_evict_ext;

    // clamp the set-bit and way configuration to the supported range
    always_comb begin
        if (r_set_bits == '0) begin
            w_s_eff = SBW'(1);
        end else if (int'(r_set_bits) > MAX_SET_BITS) begin
            w_s_eff = SBW'(MAX_SET_BITS);
        end else begin
            w_s_eff = SBW'(r_set_bits);
        end
        if (r_ways == '0) begin
            w_w_eff = WCW'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            w_w_eff = WCW'(MAX_WAYS);
        end else begin
            w_w_eff = WCW'(r_ways);
        end
        for (int j = 0; j < MAX_SET_BITS; j++) begin
            w_set_mask[j] = (j < int'(w_s_eff));
        end
    end

    assign w_set_shift = i_address >> r_off_bits;
    assign w_set       = w_set_shift[MAX_SET_BITS-1:0] & w_set_mask;
    assign w_tag_sh    = 7'(r_off_bits) + 7'(w_s_eff);
    assign w_tag_shift = i_address >> w_tag_sh;
    assign w_tag       = w_tag_shift[TAG_W-1:0];

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        w_done      = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_mem_we = 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    w_mem_re = 1'b1;
                    n_state  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    w_done   = 1'b1;
                    w_mem_we = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    slac_ram #(
        .AW (MAX_SET_BITS),
        .DW (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_set),
        .o_rdata (w_rdata)
    );

    assign w_row = w_rdata;

    slac_lookup #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .i_row  (w_row),
        .i_tag  (r_tag),
        .i_ways (w_w_eff),
        .o_res  (w_res),
        .o_way  (w_way)
    );

    assign w_clock_nx = r_clock + 64'd1;

    always_comb begin
        w_new_row              = w_row;
        w_new_row[w_way].valid = 1'b1;
        w_new_row[w_way].tag   = r_tag;
        w_new_row[w_way].stamp = w_clock_nx;
    end

    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_set;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : w_new_row;

    assign w_modify    = (r_mode == MODE_MODIFY);
    assign w_hit_inc   = {1'b0, w_res.hit} + {1'b0, w_modify};
    assign w_hit_sum   = {1'b0, r_hit} + (COUNT_WIDTH+1)'(w_hit_inc);
    assign w_miss_sum  = {1'b0, r_miss} + (COUNT_WIDTH+1)'(!w_res.hit);
    assign w_evict_sum = {1'b0, r_evict} + (COUNT_WIDTH+1)'(w_res.evict);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= SET_BITS_RST;
            r_off_bits <= OFF_BITS_RST;
            r_ways     <= WAYS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SET_BITS: r_set_bits <= i_cfg_wdata[SET_CFG_W-1:0];
                CFG_OFF_BITS: r_off_bits <= i_cfg_wdata[OFF_CFG_W-1:0];
                CFG_WAYS:     r_ways     <= i_cfg_wdata[WAY_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_set  <= w_set;
            r_tag  <= w_tag;
            r_mode <= i_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_hit   <= '0;
            r_miss  <= '0;
            r_evict <= '0;
        end else if (w_done) begin
            r_clock <= w_clock_nx;
            r_hit   <= w_hit_sum[COUNT_WIDTH] ? '1 : w_hit_sum[COUNT_WIDTH-1:0];
            r_miss  <= w_miss_sum[COUNT_WIDTH] ? '1 : w_miss_sum[COUNT_WIDTH-1:0];
            r_evict <= w_evict_sum[COUNT_WIDTH] ? '1 : w_evict_sum[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_done) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_outcome <= w_res.outcome;
            r_second  <= w_modify;
        end
    end

    // totals only move on a new result, so they track the held response
    assign w_hit_ext   = EXT_W'(r_hit);
    assign w_miss_ext  = EXT_W'(r_miss);
    assign w_evict_ext = EXT_W'(r_evict);

    assign o_rsp_valid      = r_rsp_valid;
    assign o_outcome        = r_outcome;
    assign o_second_hit     = r_second;
    assign o_hit_total      = w_hit_ext[31:0];
    assign o_miss_total     = w_miss_ext[31:0];
    assign o_eviction_total = w_evict_ext[31:0];

    `ASSERT_NEVER(a_no_req_in_clear, i_clk, i_rst_n, (r_state == ST_CLEAR) && o_req_ready)
    `ASSERT_CHK(a_accept_to_eval, i_clk, i_rst_n, (i_req_valid && o_req_ready) |=> (r_state == ST_EVAL))
    `ASSERT_CHK(a_clock_step, i_clk, i_rst_n, w_done |=> (r_clock == $past(r_clock) + 64'd1))
    `ASSERT_CHK(a_hit_monotonic, i_clk, i_rst_n, 1'b1 |=> (r_hit >= $past(r_hit)))
    `ASSERT_CHK(a_rsp_after_done, i_clk, i_rst_n, w_done |=> o_rsp_valid)

endmodule

// ===== src/slac_ram.sv =====
module slac_ram #(
    parameter int AW = 6,
    parameter int DW = 1024
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [1 << AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/slac_lookup.sv =====
module slac_lookup #(
    parameter int MAX_WAYS = 8,
    localparam int WIDX = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int WCW = $clog2(MAX_WAYS + 1)
) (
    input  slac_pkg::t_line [MAX_WAYS-1:0] i_row,
    input  logic [slac_pkg::TAG_W-1:0]     i_tag,
    input  logic [WCW-1:0]                 i_ways,
    output slac_pkg::t_lookup              o_res,
    output logic [WIDX-1:0]                o_way
);

    import slac_pkg::*;

    localparam int NL = 1 << $clog2(MAX_WAYS);

    logic [MAX_WAYS-1:0] w_use;
    logic [MAX_WAYS-1:0] w_match;
    logic [MAX_WAYS-1:0] w_free;
    logic                w_hit_any;
    logic                w_free_any;
    logic [WIDX-1:0]     w_hit_way;
    logic [WIDX-1:0]     w_free_way;
    logic [2*NL-1:0]     w_en;
    logic [STAMP_W-1:0]  w_st [2*NL];
    logic [WIDX-1:0]     w_ix [2*NL];

    always_comb begin
        w_hit_way  = '0;
        w_free_way = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_use[i]   = (i < int'(i_ways));
            w_match[i] = w_use[i] && i_row[i].valid && (i_row[i].tag == i_tag);
            w_free[i]  = w_use[i] && !i_row[i].valid;
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_way = WIDX'(i);
            end
            if (w_free[i]) begin
                w_free_way = WIDX'(i);
            end
        end
        w_hit_any  = |w_match;
        w_free_any = |w_free;
    end

    // least recently used: smallest stamp, lower way wins ties
    always_comb begin
        for (int k = 0; k < 2 * NL; k++) begin
            w_en[k] = 1'b0;
            w_st[k] = '0;
            w_ix[k] = '0;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_en[NL+i] = w_use[i];
            w_st[NL+i] = i_row[i].stamp;
            w_ix[NL+i] = WIDX'(i);
        end
        for (int k = NL - 1; k >= 1; k--) begin
            if (w_en[2*k+1] && (!w_en[2*k] || (w_st[2*k+1] < w_st[2*k]))) begin
                w_en[k] = 1'b1;
                w_st[k] = w_st[2*k+1];
                w_ix[k] = w_ix[2*k+1];
            end else begin
                w_en[k] = w_en[2*k];
                w_st[k] = w_st[2*k];
                w_ix[k] = w_ix[2*k];
            end
        end
    end

    always_comb begin
        o_res.hit   = w_hit_any;
        o_res.evict = !w_hit_any && !w_free_any;
        if (w_hit_any) begin
            o_res.outcome = OUT_HIT;
            o_way         = w_hit_way;
        end else if (w_free_any) begin
            o_res.outcome = OUT_MISS;
            o_way         = w_free_way;
        end else begin
            o_res.outcome = OUT_EVICT;
            o_way         = w_ix[1];
        end
    end

endmodule
